// File: rtl/uart_rx_tx_baud_ticked_defines.svh
// Assertion macros shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef UART_RX_TX_BAUD_TICKED_DEFINES_SVH
`define UART_RX_TX_BAUD_TICKED_DEFINES_SVH

`ifndef SYNTHESIS

`define URTB_ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("urtb: implication check failed");

`define URTB_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("urtb: next-cycle check failed");

`else

`define URTB_ASSERT_IMPLY(name, cond, prop)

`define URTB_ASSERT_NEXT(name, cond, prop)

`endif

`endif

// File: rtl/urtb_pkg.sv
`timescale 1ns / 1ps

package urtb_pkg;

    localparam int URTB_TX_FIFO_DEPTH = 16;

    localparam int DIVIDER_W  = 20;
    localparam int DBITS_W    = 4;
    localparam int CYCLES_W   = 16;
    localparam int TICK_W     = 21;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 4;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [DIVIDER_W-1:0] DIVIDER_RESET   = DIVIDER_W'(1084);
    localparam logic [DBITS_W-1:0]   DATA_BITS_RESET = DBITS_W'(8);

    // Register index, taken from paddr[2]
    localparam logic REG_BAUD_DIVIDER = 1'b0;
    localparam logic REG_DATA_BITS    = 1'b1;

    // Receiver phases
    localparam logic [1:0] RX_WAIT_IDLE  = 2'd0;
    localparam logic [1:0] RX_WAIT_START = 2'd1;
    localparam logic [1:0] RX_DATA       = 2'd2;
    localparam logic [1:0] RX_STOP       = 2'd3;

    // Transmitter phases
    localparam logic [1:0] TX_START = 2'd0;
    localparam logic [1:0] TX_DATA  = 2'd1;
    localparam logic [1:0] TX_STOP  = 2'd2;
    localparam logic [1:0] TX_END   = 2'd3;

    // Bit positions in m_tdata
    localparam int OUT_TX_LEVEL_BIT = 0;
    localparam int OUT_RX_VALID_BIT = 1;
    localparam int OUT_RX_BYTE_LSB  = 2;
    localparam int OUT_FERR_BIT     = 10;
    localparam int OUT_DROP_BIT     = 11;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// File: rtl/urtb_fifo.sv
`timescale 1ns / 1ps

module urtb_fifo import urtb_pkg::*; #(
    parameter int DEPTH = URTB_TX_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [BYTE_W-1:0] push_data,
    input  logic              pop,
    output logic [BYTE_W-1:0] pop_data,
    output fifo_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic [LVL_W-1:0]  level_reg;
    logic [LVL_W-1:0]  level_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              bypass_reg;
    logic [BYTE_W-1:0] bypass_data_reg;
    logic [BYTE_W-1:0] front;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

    assign status.empty = (level_reg == '0);
    assign status.full  = (level_reg == LVL_W'(DEPTH));

    assign head_next  = pop  ? wrap_inc(head_reg) : head_reg;
    assign tail_next  = push ? wrap_inc(tail_reg) : tail_reg;
    assign level_next = level_reg + LVL_W'(push) - LVL_W'(pop);

    // The entry at the head is read ahead of time; a write to that same entry
    // in the cycle of the read is forwarded instead.
    assign front = bypass_reg ? bypass_data_reg : rd_data_reg;

    // An empty queue can still pop the byte pushed by the same item.
    assign pop_data = status.empty ? push_data : front;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
        rd_data_reg     <= mem[head_next];
        bypass_data_reg <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            level_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            level_reg  <= level_next;
            bypass_reg <= push && (tail_reg == head_next);
        end
    end

endmodule

// File: rtl/uart_rx_tx_baud_ticked.sv
`timescale 1ns / 1ps
// UART transceiver stepped by a baud-tick divider.
// Each item on the s_ channel carries the cycles elapsed since the previous item, the
// sampled receive line level and an optional byte to queue for transmission. The
// item adds to a tick counter; once the counter reaches baud_divider it clears and
// one receive step and one transmit step run. Each item gives exactly one item on
// the m_ channel: the transmit line level, a received byte with its valid flag, a
// framing error flag and a flag for a byte dropped because the transmit queue was full.
// An item passes through an input register and then a result register, from which
// its result is offered on the m_ channel. One item is taken every cycle when
// m_tready stays high. baud_divider and data_bits are written over the APB port;
// the user must write them only while no item is in flight, as the block itself does not enforce this.
// Reset clears the counters and phases, empties the transmit queue, sets the line
// high, baud_divider to 1084 and data_bits to 8.
// When m_tready is low the result register holds, one further item waits in the
// input register, and then s_tready falls until the result is taken.

`include "uart_rx_tx_baud_ticked_defines.svh"

module uart_rx_tx_baud_ticked import urtb_pkg::*; #(
    parameter int TX_FIFO_DEPTH = URTB_TX_FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] cycles_elapsed, [16] rx_level, [17] push_valid, [25:18] push_byte
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] tx_level, [1] rx_valid, [9:2] rx_byte, [10] framing_error, [11] push_dropped
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration
    logic [DIVIDER_W-1:0] divider_reg;
    logic [DBITS_W-1:0]   data_bits_reg;
    logic                 cfg_write;

    // Input and result registers
    logic                 in_valid_reg;
    logic [CYCLES_W-1:0]  cycles_reg;
    logic                 rx_level_reg;
    logic                 push_valid_reg;
    logic [BYTE_W-1:0]    push_byte_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 advance;
    logic                 fire;
    logic                 take_in;

    // Block state
    logic [TICK_W-1:0]    tick_reg;
    logic [TICK_W-1:0]    tick_next;
    logic [1:0]           rx_phase_reg;
    logic [1:0]           rx_phase_next;
    logic [CNT_W-1:0]     rx_count_reg;
    logic [CNT_W-1:0]     rx_count_next;
    logic [BYTE_W-1:0]    rx_shift_reg;
    logic [BYTE_W-1:0]    rx_shift_next;
    logic [1:0]           tx_phase_reg;
    logic [1:0]           tx_phase_next;
    logic [CNT_W-1:0]     tx_count_reg;
    logic [CNT_W-1:0]     tx_count_next;
    logic [BYTE_W-1:0]    tx_shift_reg;
    logic [BYTE_W-1:0]    tx_shift_next;
    logic                 tx_line_reg;
    logic                 tx_line_next;

    // Step logic
    logic [TICK_W-1:0]    tick_sum;
    logic                 baud;
    logic                 push_ok;
    logic                 fifo_pop;
    logic [BYTE_W-1:0]    pop_data;
    fifo_status_t         fifo_st;
    logic [CNT_W-1:0]     rx_count_inc;
    logic [BYTE_W-1:0]    rx_shift_set;
    logic [CNT_W-1:0]     tx_count_inc;
    logic                 rx_valid;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 framing_error;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_BAUD_DIVIDER: prdata = APB_DATA_W'(divider_reg);
            REG_DATA_BITS:    prdata = APB_DATA_W'(data_bits_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg   <= DIVIDER_RESET;
            data_bits_reg <= DATA_BITS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_BAUD_DIVIDER)
            begin
                divider_reg <= pwdata[DIVIDER_W-1:0];
            end
            else
            begin
                data_bits_reg <= pwdata[DBITS_W-1:0];
            end
        end
    end

    // ---------------- Handshake ----------------
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cycles_reg     <= s_tdata[15:0];
            rx_level_reg   <= s_tdata[16];
            push_valid_reg <= s_tdata[17];
            push_byte_reg  <= s_tdata[25:18];
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------- Transmit queue ----------------
    assign push_ok = fire && push_valid_reg && !fifo_st.full;

    urtb_fifo #(
        .DEPTH (TX_FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_ok),
        .push_data (push_byte_reg),
        .pop       (fifo_pop),
        .pop_data  (pop_data),
        .status    (fifo_st)
    );

    // ---------------- Baud step ----------------
    assign tick_sum     = tick_reg + TICK_W'(cycles_reg);
    assign baud         = tick_sum >= TICK_W'(divider_reg);
    assign tick_next    = baud ? '0 : tick_sum;
    assign rx_count_inc = rx_count_reg + CNT_W'(1);
    assign tx_count_inc = tx_count_reg + CNT_W'(1);
    assign rx_shift_set = rx_shift_reg | (BYTE_W'(1) << rx_count_reg[2:0]);

    assign fifo_pop = fire && baud && (tx_phase_reg == TX_START)
                      && (!fifo_st.empty || push_ok);

    always_comb
    begin
        rx_phase_next = rx_phase_reg;
        rx_count_next = rx_count_reg;
        rx_shift_next = rx_shift_reg;
        rx_valid      = 1'b0;
        rx_byte       = '0;
        framing_error = 1'b0;
        if (baud)
        begin
            case (rx_phase_reg)
                RX_WAIT_IDLE:
                begin
                    if (rx_level_reg)
                    begin
                        rx_phase_next = RX_WAIT_START;
                    end
                end
                RX_WAIT_START:
                begin
                    if (!rx_level_reg)
                    begin
                        rx_phase_next = RX_DATA;
                    end
                end
                RX_DATA:
                begin
                    // Bits past the eighth are sampled but not stored.
                    if (!rx_count_reg[3] && rx_level_reg)
                    begin
                        rx_shift_next = rx_shift_set;
                    end
                    rx_count_next = rx_count_inc;
                    if ((rx_count_inc >= data_bits_reg) || (rx_count_inc == '0))
                    begin
                        rx_valid      = 1'b1;
                        rx_byte       = rx_shift_next;
                        rx_shift_next = '0;
                        rx_count_next = '0;
                        rx_phase_next = RX_STOP;
                    end
                end
                RX_STOP:
                begin
                    if (!rx_level_reg)
                    begin
                        framing_error = 1'b1;
                        rx_phase_next = RX_WAIT_IDLE;
                    end
                    else
                    begin
                        rx_phase_next = RX_WAIT_START;
                    end
                end
                default:
                begin
                    rx_phase_next = RX_WAIT_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        tx_phase_next = tx_phase_reg;
        tx_count_next = tx_count_reg;
        tx_shift_next = tx_shift_reg;
        tx_line_next  = tx_line_reg;
        if (baud)
        begin
            case (tx_phase_reg)
                TX_START:
                begin
                    if (fifo_pop)
                    begin
                        tx_shift_next = pop_data;
                        tx_phase_next = TX_DATA;
                        tx_line_next  = 1'b0;
                    end
                end
                TX_DATA:
                begin
                    tx_line_next  = tx_shift_reg[0];
                    tx_shift_next = tx_shift_reg >> 1;
                    tx_count_next = tx_count_inc;
                    if ((tx_count_inc >= data_bits_reg) || (tx_count_inc == '0))
                    begin
                        tx_phase_next = TX_STOP;
                    end
                end
                TX_STOP:
                begin
                    tx_line_next  = 1'b1;
                    tx_phase_next = TX_END;
                end
                TX_END:
                begin
                    tx_count_next = '0;
                    tx_phase_next = TX_START;
                end
                default:
                begin
                    tx_phase_next = TX_START;
                end
            endcase
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[OUT_TX_LEVEL_BIT] = tx_line_next;
        out_data_next[OUT_RX_VALID_BIT] = rx_valid;
        out_data_next[OUT_RX_BYTE_LSB +: BYTE_W] = rx_byte;
        out_data_next[OUT_FERR_BIT] = framing_error;
        out_data_next[OUT_DROP_BIT] = push_valid_reg && fifo_st.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            rx_phase_reg <= RX_WAIT_IDLE;
            rx_count_reg <= '0;
            rx_shift_reg <= '0;
            tx_phase_reg <= TX_START;
            tx_count_reg <= '0;
            tx_shift_reg <= '0;
            tx_line_reg  <= 1'b1;
        end
        else if (fire)
        begin
            tick_reg     <= tick_next;
            rx_phase_reg <= rx_phase_next;
            rx_count_reg <= rx_count_next;
            rx_shift_reg <= rx_shift_next;
            tx_phase_reg <= tx_phase_next;
            tx_count_reg <= tx_count_next;
            tx_shift_reg <= tx_shift_next;
            tx_line_reg  <= tx_line_next;
        end
    end

    // ---------------- Checks ----------------
    `URTB_ASSERT_IMPLY(a_ready_when_empty, !out_valid_reg, s_tready)
    `URTB_ASSERT_IMPLY(a_queue_status, 1'b1, !(fifo_st.full && fifo_st.empty))
    `URTB_ASSERT_IMPLY(a_rx_flags_exclusive, out_valid_reg,
        !(out_data_reg[OUT_RX_VALID_BIT] && out_data_reg[OUT_FERR_BIT]))
    `URTB_ASSERT_NEXT(a_drop_reported, fire && push_valid_reg && fifo_st.full,
        out_data_reg[OUT_DROP_BIT])

endmodule

// File: tb/uart_rx_tx_baud_ticked_test.sv
`timescale 1ns / 1ps

module uart_rx_tx_baud_ticked_test;
    import urtb_pkg::*;

    // Input item, packed in the same order as s_tdata.
    typedef struct packed {
        logic [7:0]  push_byte;
        logic        push_valid;
        logic        rx_level;
        logic [15:0] cycles;
    } line_item_t;

    // Result item, packed in the same order as m_tdata[11:0].
    typedef struct packed {
        logic       push_dropped;
        logic       framing_error;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_level;
    } line_result_t;

    typedef struct {
        bit           cfg;
        logic [19:0]  div;
        logic [3:0]   nbits;
        line_item_t   item;
        bit           typed;
        line_result_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [15:0] cycles_elapsed, [16] rx_level, [17] push_valid, [25:18] push_byte
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] tx_level, [1] rx_valid, [9:2] rx_byte, [10] framing_error, [11] push_dropped
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    uart_rx_tx_baud_ticked dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Line format currently programmed, and the predicted state of the transceiver.
    logic [19:0]       cur_divider;
    logic [3:0]        cur_dbits;
    logic [TICK_W-1:0] tick_cnt;
    logic [1:0]        rx_ph;
    logic [3:0]        rx_cnt;
    logic [7:0]        rx_sh;
    logic [1:0]        tx_ph;
    logic [3:0]        tx_cnt;
    logic [7:0]        tx_sh;
    logic              tx_ln;
    logic [7:0]        fifo_mem [URTB_TX_FIFO_DEPTH];
    int                fifo_rd;
    int                fifo_wr;
    int                fifo_cnt;

    line_result_t pending_results[$];
    stim_row_t    stim_rows[$];
    bit           rx_wave[$];
    int           mismatches = 0;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           push_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [11:0] want,
                                   input logic [11:0] got);
        $display("mismatch at %0t: %s, wanted %0h, got %0h", $realtime, what, want, got);
        mismatches++;
    endtask

    function automatic void clear_line_state();
        cur_divider = DIVIDER_RESET;
        cur_dbits   = DATA_BITS_RESET;
        tick_cnt    = '0;
        rx_ph       = RX_WAIT_IDLE;
        rx_cnt      = '0;
        rx_sh       = '0;
        tx_ph       = TX_START;
        tx_cnt      = '0;
        tx_sh       = '0;
        tx_ln       = 1'b1;
        fifo_rd     = 0;
        fifo_wr     = 0;
        fifo_cnt    = 0;
    endfunction

    // Advances the predicted state by one item and gives the line levels and flags it causes.
    function automatic line_result_t uart_step(input line_item_t it);
        line_result_t r;
        r = '0;
        if (it.push_valid)
        begin
            if (fifo_cnt >= URTB_TX_FIFO_DEPTH)
                r.push_dropped = 1'b1;
            else
            begin
                fifo_mem[fifo_wr] = it.push_byte;
                fifo_wr = (fifo_wr + 1) % URTB_TX_FIFO_DEPTH;
                fifo_cnt++;
            end
        end
        tick_cnt = tick_cnt + TICK_W'(it.cycles);
        if (tick_cnt >= {1'b0, cur_divider})
        begin
            tick_cnt = '0;
            case (rx_ph)
                RX_WAIT_IDLE:
                    if (it.rx_level)
                        rx_ph = RX_WAIT_START;
                RX_WAIT_START:
                    if (!it.rx_level)
                        rx_ph = RX_DATA;
                RX_DATA:
                begin
                    if (rx_cnt < 4'd8 && it.rx_level)
                        rx_sh[rx_cnt[2:0]] = 1'b1;
                    rx_cnt = rx_cnt + 4'd1;
                    if (rx_cnt >= cur_dbits || rx_cnt == 4'd0)
                    begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = rx_sh;
                        rx_sh      = '0;
                        rx_cnt     = '0;
                        rx_ph      = RX_STOP;
                    end
                end
                default:
                    if (!it.rx_level)
                    begin
                        r.framing_error = 1'b1;
                        rx_ph = RX_WAIT_IDLE;
                    end
                    else
                        rx_ph = RX_WAIT_START;
            endcase
            case (tx_ph)
                TX_START:
                    if (fifo_cnt != 0)
                    begin
                        tx_sh   = fifo_mem[fifo_rd];
                        fifo_rd = (fifo_rd + 1) % URTB_TX_FIFO_DEPTH;
                        fifo_cnt--;
                        tx_ph   = TX_DATA;
                        tx_ln   = 1'b0;
                    end
                TX_DATA:
                begin
                    tx_ln  = tx_sh[0];
                    tx_sh  = tx_sh >> 1;
                    tx_cnt = tx_cnt + 4'd1;
                    if (tx_cnt >= cur_dbits || tx_cnt == 4'd0)
                        tx_ph = TX_STOP;
                end
                TX_STOP:
                begin
                    tx_ln = 1'b1;
                    tx_ph = TX_END;
                end
                default:
                begin
                    tx_cnt = '0;
                    tx_ph  = TX_START;
                end
            endcase
        end
        r.tx_level = tx_ln;
        return r;
    endfunction

    // Most frames are well formed; the rest are framing errors or plain noise on the line.
    function automatic void queue_rx_frame();
        int nbits;
        nbits = (cur_dbits == 0) ? 1 : int'(cur_dbits);
        if ($urandom_range(99) < 80)
        begin
            repeat ($urandom_range(1, 3)) rx_wave.push_back(1'b1);
            rx_wave.push_back(1'b0);
            repeat (nbits) rx_wave.push_back(1'($urandom_range(1)));
            rx_wave.push_back($urandom_range(99) < 85);
        end
        else
            repeat ($urandom_range(1, 6)) rx_wave.push_back(1'($urandom_range(1)));
    endfunction

    function automatic line_item_t random_item();
        line_item_t it;
        int hi;
        case ($urandom_range(9))
            0: it.cycles = 16'h0000;
            1: it.cycles = 16'hFFFF;
            2, 3: it.cycles = 16'($urandom_range(65535));
            default:
            begin
                hi = (cur_divider > 20'd65534) ? 65535 : int'(cur_divider) + 1;
                it.cycles = 16'($urandom_range(hi));
            end
        endcase
        // The line level only matters on items that run a baud step.
        if (tick_cnt + TICK_W'(it.cycles) >= {1'b0, cur_divider})
        begin
            if (rx_wave.size() == 0)
                queue_rx_frame();
            it.rx_level = rx_wave.pop_front();
        end
        else
            it.rx_level = 1'($urandom_range(1));
        it.push_valid = ($urandom_range(99) < push_pct);
        it.push_byte  = 8'($urandom_range(255));
        return it;
    endfunction

    task automatic drive_item(input line_item_t it, input bit typed, input line_result_t want);
        line_result_t r;
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 8)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = uart_step(it);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_line_format(input logic [19:0] div, input logic [3:0] nbits);
        wait_for_idle();
        apb_write({REG_BAUD_DIVIDER, 2'b00}, 32'(div));
        apb_write({REG_DATA_BITS, 2'b00}, 32'(nbits));
        cur_divider = div;
        cur_dbits   = nbits;
    endtask

    function automatic void add_row(input bit cfg, input logic [19:0] div,
                                    input logic [3:0] nbits, input logic [15:0] cyc,
                                    input logic lvl, input logic push,
                                    input logic [7:0] pbyte, input bit typed,
                                    input logic [11:0] want);
        stim_row_t row;
        row.cfg   = cfg;
        row.div   = div;
        row.nbits = nbits;
        row.item  = {pbyte, push, lvl, cyc};
        row.typed = typed;
        row.want  = line_result_t'(want);
        stim_rows.push_back(row);
    endfunction

    // Results are taken whenever the receiver is ready, and compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        line_result_t got;
        line_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = line_result_t'(m_tdata[11:0]);
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 12'h000, 12'(got));
            else
            begin
                want = pending_results.pop_front();
                if (got.tx_level !== want.tx_level)
                    report_mismatch("tx_level", 12'(want.tx_level), 12'(got.tx_level));
                if (got.rx_valid !== want.rx_valid)
                    report_mismatch("rx_valid", 12'(want.rx_valid), 12'(got.rx_valid));
                if (got.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", 12'(want.rx_byte), 12'(got.rx_byte));
                if (got.framing_error !== want.framing_error)
                    report_mismatch("framing_error", 12'(want.framing_error),
                                    12'(got.framing_error));
                if (got.push_dropped !== want.push_dropped)
                    report_mismatch("push_dropped", 12'(want.push_dropped),
                                    12'(got.push_dropped));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : stimulus
        logic [19:0] set_div [8];
        logic [3:0]  set_bits [8];
        logic [7:0]  fill_bytes [15];
        set_div  = '{20'd0, 20'd3, 20'd1048575, 20'd0, 20'd2, 20'd100, 20'd1, 20'd0};
        set_bits = '{4'd8, 4'd7, 4'd8, 4'd0, 4'd15, 4'd8, 4'd9, 4'd7};
        fill_bytes = '{8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00,
                       8'hC3, 8'h3C, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h81};

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        send_idle_pct = 26;
        recv_idle_pct = 59;
        push_pct      = 30;
        clear_line_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the transmit queue without a baud step, overflow it, then step on the
        // exact divider boundary.
        add_row(0, 0, 0, 16'd0, 1'b0, 1'b1, 8'h00, 1, 12'h001);
        for (int i = 0; i < 15; i++)
            add_row(0, 0, 0, (i == 14) ? 16'd1083 : 16'd0, 1'(i), 1'b1, fill_bytes[i], 0, 0);
        add_row(0, 0, 0, 16'd0, 1'b0, 1'b1, 8'h5A, 1, 12'h801);
        add_row(0, 0, 0, 16'd1, 1'b1, 1'b0, 8'h00, 1, 12'h000);
        // Divider zero with one data bit: a good frame with a high stop bit, then a low one.
        add_row(1, 20'd0, 4'd1, 16'hFFFF, 1'b0, 1'b0, 8'hFF, 0, 0);
        add_row(0, 0, 0, 16'd0, 1'b1, 1'b0, 8'h00, 0, 0);
        add_row(0, 0, 0, 16'd0, 1'b1, 1'b0, 8'h00, 0, 0);
        add_row(0, 0, 0, 16'd0, 1'b0, 1'b0, 8'h00, 0, 0);
        add_row(0, 0, 0, 16'd0, 1'b0, 1'b0, 8'h00, 0, 0);
        add_row(0, 0, 0, 16'd0, 1'b0, 1'b0, 8'h00, 0, 0);
        // Zero data length behaves as a single bit.
        add_row(1, 20'd0, 4'd0, 16'd0, 1'b1, 1'b1, 8'hFF, 0, 0);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].cfg)
                set_line_format(stim_rows[i].div, stim_rows[i].nbits);
            drive_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
        end

        for (int s = 0; s < 8; s++)
        begin
            set_line_format(set_div[s], set_bits[s]);
            if (s < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 59;
            end
            else if (s < 6)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            push_pct = $urandom_range(5, 50);
            rx_wave.delete();
            repeat (153)
                drive_item(random_item(), 0, '0);
        end

        wait_for_idle();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/urtb_pkg.sv
rtl/urtb_fifo.sv
rtl/uart_rx_tx_baud_ticked.sv
tb/uart_rx_tx_baud_ticked_test.sv
